FILE: rtl/core/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// shared types, character codes and helpers for the url path decoder
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned MAX_CAPACITY = 4096;
  localparam int unsigned CFG_W        = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;
  localparam int unsigned JOB_DEPTH    = 4;

  localparam logic [7:0] CH_QUERY     = 8'h3f;  // '?'
  localparam logic [7:0] CH_HASH      = 8'h23;  // '#'
  localparam logic [7:0] CH_PERCENT   = 8'h25;  // '%'
  localparam logic [7:0] CH_DOT       = 8'h2e;  // '.'
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;  // '\'
  localparam logic [7:0] CH_NUL       = 8'h00;

  // escape progress, one-hot
  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HELD = 3'b100
  } esc_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_status;
    logic       path_error;
  } out_item_t;

  // results caused by one input beat: up to two bytes, then maybe a status
  typedef struct packed {
    logic [1:0] nbytes;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       status;
    logic       err;
  } job_t;

  typedef struct packed {
    logic ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_val(logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// accepts encoded characters, tracks escape and path state, builds result jobs
// ----------------------------------------------------------------------------
module upd_front
  import upd_pkg::*;
#(
  parameter int unsigned MaxCapacity = MAX_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  in_item_t         in_item_i,
  output logic             job_push_o,
  output job_t             job_o
);

  localparam int unsigned CntW = $clog2(MaxCapacity + 1);
  localparam int unsigned CmpW = ((CntW > CFG_W) ? CntW : CFG_W) + 1;
  localparam logic [CmpW-1:0] MaxCapC = CmpW'(MaxCapacity);

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            ld;
    logic            dd;
    logic            f;
    logic            ok;
  } path_t;

  logic [CFG_W-1:0] cap_q;
  esc_e             esc_q, esc_d;
  logic [7:0]       held_q, held_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             last_dot_q, last_dot_d;
  logic             dotdot_q, dotdot_d;
  logic             stopped_q, stopped_d;
  logic             failed_q, failed_d;
  logic [CmpW-1:0]  cap_ext, cap_eff;

  assign cap_ext = CmpW'(cap_q);
  assign cap_eff = (cap_ext > MaxCapC) ? MaxCapC : cap_ext;

  function automatic path_t emit(path_t s, logic [7:0] v, logic [CmpW-1:0] cap);
    path_t r;
    r    = s;
    r.ok = 1'b0;
    if (!s.f) begin
      if (v == CH_NUL || v == CH_BACKSLASH || (CmpW'(s.cnt) + CmpW'(1)) >= cap) begin
        r.f = 1'b1;
      end else begin
        r.cnt = s.cnt + CntW'(1);
        if (v == CH_DOT && s.ld) begin
          r.dd = 1'b1;
        end
        r.ld = (v == CH_DOT);
        r.ok = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic job_t add_byte(job_t j, logic [7:0] v);
    job_t r;
    r = j;
    if (j.nbytes == 2'd0) begin
      r.byte0 = v;
    end else begin
      r.byte1 = v;
    end
    r.nbytes = j.nbytes + 2'd1;
    return r;
  endfunction

  always_comb begin
    path_t      p;
    job_t       j;
    hex_t       hi, lo;
    logic [7:0] c;
    c          = in_item_i.in_char;
    p          = '{cnt: count_q, ld: last_dot_q, dd: dotdot_q, f: failed_q, ok: 1'b0};
    j          = '0;
    esc_d      = esc_q;
    held_d     = held_q;
    stopped_d  = stopped_q;
    hi         = hex_val(held_q);
    lo         = hex_val(c);
    if (in_item_i.end_of_string) begin
      if (!p.f && !stopped_q) begin
        case (esc_q)
          ESC_PCT: begin
            p = emit(p, CH_PERCENT, cap_eff);
            if (p.ok) j = add_byte(j, CH_PERCENT);
          end
          ESC_HELD: begin
            p = emit(p, CH_PERCENT, cap_eff);
            if (p.ok) j = add_byte(j, CH_PERCENT);
            if (!p.f && held_q != CH_QUERY && held_q != CH_HASH) begin
              p = emit(p, held_q, cap_eff);
              if (p.ok) j = add_byte(j, held_q);
            end
          end
          default: begin
          end
        endcase
      end
      j.status  = 1'b1;
      j.err     = p.f | p.dd;
      // path done, back to reset values
      esc_d     = ESC_NONE;
      held_d    = '0;
      stopped_d = 1'b0;
      p         = '0;
    end else if (!p.f && !stopped_q) begin
      case (esc_q)
        ESC_PCT: begin
          held_d = c;
          esc_d  = ESC_HELD;
        end
        ESC_HELD: begin
          esc_d = ESC_NONE;
          if (!hi.ok || !lo.ok) begin
            p.f = 1'b1;
          end else begin
            p = emit(p, {hi.nib, lo.nib}, cap_eff);
            if (p.ok) j = add_byte(j, {hi.nib, lo.nib});
          end
        end
        default: begin
          esc_d = ESC_NONE;
          if (c == CH_PERCENT) begin
            esc_d = ESC_PCT;
          end else if (c == CH_QUERY || c == CH_HASH) begin
            stopped_d = 1'b1;
          end else begin
            p = emit(p, c, cap_eff);
            if (p.ok) j = add_byte(j, c);
          end
        end
      endcase
    end
    count_d    = p.cnt;
    last_dot_d = p.ld;
    dotdot_d   = p.dd;
    failed_d   = p.f;
    job_o      = j;
    job_push_o = in_valid_i && (j.nbytes != 2'd0 || j.status);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      esc_q      <= ESC_NONE;
      held_q     <= '0;
      count_q    <= '0;
      last_dot_q <= 1'b0;
      dotdot_q   <= 1'b0;
      stopped_q  <= 1'b0;
      failed_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_valid_i) begin
        esc_q      <= esc_d;
        held_q     <= held_d;
        count_q    <= count_d;
        last_dot_q <= last_dot_d;
        dotdot_q   <= dotdot_d;
        stopped_q  <= stopped_d;
        failed_q   <= failed_d;
      end
    end
  end

  a_end_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_item_i.end_of_string |-> job_push_o && job_o.status)
    else $error("end of path without status result");

  a_end_clears_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_item_i.end_of_string |=>
      count_q == '0 && !failed_q && !stopped_q && !dotdot_q && esc_q == ESC_NONE)
    else $error("path state not cleared after end");

  a_no_bytes_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_item_i.end_of_string && (failed_q || stopped_q) |-> !job_push_o)
    else $error("result produced after error or stop");

endmodule

FILE: rtl/core/upd_fifo.sv
// ----------------------------------------------------------------------------
// upd_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
module upd_fifo
  import upd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(JOB_DEPTH);

  job_t              mem_q [JOB_DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(JOB_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(JOB_DEPTH))
    else $error("job queue over depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (PtrW+1)'(JOB_DEPTH)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/core/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// walks the head job and hands out its results one beat at a time
// ----------------------------------------------------------------------------
module upd_back
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_pop_o,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item_o
);

  logic [1:0] idx_q;
  logic [1:0] total;
  logic       last;
  logic       take;

  assign total = job_i.nbytes + 2'(job_i.status);
  assign last  = (idx_q == total - 2'd1);
  assign empty = job_empty_i;
  assign take  = pop && !job_empty_i;
  assign job_pop_o = take && last;

  always_comb begin
    out_item_o = '0;
    if (idx_q < job_i.nbytes) begin
      out_item_o.out_char = (idx_q == 2'd0) ? job_i.byte0 : job_i.byte1;
    end else begin
      out_item_o.is_status  = 1'b1;
      out_item_o.path_error = job_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> idx_q < total)
    else $error("result index beyond job");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> idx_q == 2'd0)
    else $error("index not rewound after job");

  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !last |=> idx_q == $past(idx_q) + 2'd1)
    else $error("index did not advance");

endmodule

FILE: rtl/core/url_path_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_path_percent_decoder
// streaming percent decoder for url paths with end-of-path status
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | beat
//  ---------+--------------------+--------------------------------------------
//  input    | push / full        | in_item_i  : in_char, end_of_string
//  result   | empty / pop        | out_item_o : out_char, is_status, path_error
//  config   | cfg_we_i           | cfg_wdata_i: output_capacity
//
//  one input beat accepted per cycle while the job queue has room
//  each input beat leaves zero to three result beats; one result beat per cycle while pop is held
//  front updates path state at accept, back drains queued jobs on its own
//  full rises only when all four job slots hold undelivered results
//  reset clears path state, empties the queue, capacity back to 4096
//
module url_path_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned MaxCapacity = MAX_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // encoded characters in
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item_i,
  // decoded bytes and status out
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item_o
);

  logic in_valid;
  logic job_push;
  logic job_pop;
  logic job_empty;
  job_t job_new;
  job_t job_head;

  // beat accepted on the input side
  assign in_valid = push && !full;

  // front: escape tracking, capacity and dot-dot checks, status build
  upd_front #(
    .MaxCapacity (MaxCapacity)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item_i),
    .job_push_o  (job_push),
    .job_o       (job_new)
  );

  // jobs decouple the two sides so a stalled reader does not block decoding until the job queue fills
  upd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_new),
    .pop_i   (job_pop),
    .head_o  (job_head),
    .full_o  (full),
    .empty_o (job_empty)
  );

  // back: serialises each job into result beats
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: dv/url_path_percent_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_path_percent_decoder_tb
// self-checking bench for the streaming url path percent decoder
// ----------------------------------------------------------------------------
// Encoded path characters are queued by the stimulus process and offered by
// a clocked driver. A clocked monitor keeps its own decoder state, works out
// the decoded bytes and the end-of-path status for every accepted beat, and
// compares each popped result beat with the oldest outstanding prediction.
// The output capacity is swept through its extremes while the block is idle.
// ----------------------------------------------------------------------------
module url_path_percent_decoder_tb;
  import upd_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles with no beat moving on either side
  localparam int HOLD_CYCLES = 120;    // long result-side hold-off
  localparam int DRAIN_WAIT  = 8;      // settle time once nothing is outstanding
  localparam int MAX_REPORTS = 10;

  // --------------------------------------------------------------------------
  // clock, reset and block ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic             clk         = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             push        = 1'b0;
  logic             full;
  in_item_t         in_item_i   = '0;
  logic             empty;
  logic             pop         = 1'b0;
  out_item_t        out_item_o;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  url_path_percent_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // --------------------------------------------------------------------------
  // shared bench state
  // --------------------------------------------------------------------------
  in_item_t  enc_chars[$];     // encoded characters still to be offered
  out_item_t decoded_out[$];   // predicted result beats, oldest first

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_took       = 1'b0;   // input beat moved at the last rising edge
  bit  hold_req      = 1'b0;   // ask the receiver for one long hold-off
  int  hold_left     = 0;
  int  queued_total  = 0;

  int  mismatches    = 0;
  int  idle_run      = 0;
  int  n_chars       = 0;
  int  n_bytes       = 0;
  int  n_paths       = 0;
  int  n_rejected    = 0;
  int  n_caps        = 0;
  int  stall_cycles  = 0;

  // --------------------------------------------------------------------------
  // decoder state as the bench sees it
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] capacity   = CAP_RESET;
  esc_e             esc_state  = ESC_NONE;
  logic [7:0]       held_char  = '0;
  int unsigned      out_count  = 0;
  bit               prev_dot   = 1'b0;
  bit               saw_dotdot = 1'b0;
  bit               at_query   = 1'b0;   // '?' or '#' ended the path
  bit               path_failed = 1'b0;

  // hex digit value, or -1 when the character is not a digit of either case
  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic clear_path();
    esc_state   = ESC_NONE;
    held_char   = '0;
    out_count   = 0;
    prev_dot    = 1'b0;
    saw_dotdot  = 1'b0;
    at_query    = 1'b0;
    path_failed = 1'b0;
  endtask

  // a byte leaves the decoder unless it is NUL, a backslash, or overruns
  // the buffer; capacities above the build maximum behave as the maximum
  task automatic put_byte(logic [7:0] v);
    int unsigned lim;
    out_item_t   beat;
    lim = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;
    if (path_failed) return;
    if (v == CH_NUL || v == CH_BACKSLASH || out_count + 1 >= lim) begin
      path_failed = 1'b1;
      return;
    end
    out_count++;
    if (v == CH_DOT && prev_dot) saw_dotdot = 1'b1;
    prev_dot        = (v == CH_DOT);
    beat.out_char   = v;
    beat.is_status  = 1'b0;
    beat.path_error = 1'b0;
    decoded_out.push_back(beat);
  endtask

  task automatic plain_char(logic [7:0] c);
    if (c == CH_QUERY || c == CH_HASH) begin
      at_query = 1'b1;
    end else begin
      put_byte(c);
    end
  endtask

  // predicted effect of one accepted input beat
  task automatic decode_beat(in_item_t it);
    int        hi;
    int        lo;
    out_item_t st;
    if (it.end_of_string) begin
      // a dangling escape goes out literally, then the held character unless it is '?' or '#'
      if (!path_failed && !at_query) begin
        case (esc_state)
          ESC_PCT: begin
            put_byte(CH_PERCENT);
          end
          ESC_HELD: begin
            put_byte(CH_PERCENT);
            if (!path_failed) plain_char(held_char);
          end
          default: ;
        endcase
      end
      st.out_char   = '0;
      st.is_status  = 1'b1;
      st.path_error = path_failed || saw_dotdot;
      decoded_out.push_back(st);
      n_paths++;
      if (st.path_error) n_rejected++;
      clear_path();
    end else if (!path_failed && !at_query) begin
      case (esc_state)
        ESC_PCT: begin
          held_char = it.in_char;
          esc_state = ESC_HELD;
        end
        ESC_HELD: begin
          hi        = nibble_of(held_char);
          lo        = nibble_of(it.in_char);
          esc_state = ESC_NONE;
          if (hi < 0 || lo < 0) begin
            path_failed = 1'b1;
          end else begin
            put_byte(8'((hi << 4) | lo));
          end
        end
        default: begin
          esc_state = ESC_NONE;
          if (it.in_char == CH_PERCENT) begin
            esc_state = ESC_PCT;
          end else begin
            plain_char(it.in_char);
          end
        end
      endcase
    end
  endtask

  task automatic report(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s want char=%02h st=%0b err=%0b got char=%02h st=%0b err=%0b",
               $time, what, want.out_char, want.is_status, want.path_error,
               got.out_char, got.is_status, got.path_error);
    end
  endtask

  // --------------------------------------------------------------------------
  // monitor: check popped beats, predict from pushed beats, watchdog last
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    in_took = rst_ni && push && !full;
    if (rst_ni) begin
      if (push && full) stall_cycles++;
      if (pop && !empty) begin
        if (decoded_out.size() == 0) begin
          report("no beat outstanding,", '0, out_item_o);
        end else begin
          want = decoded_out.pop_front();
          if (want.out_char != out_item_o.out_char ||
              want.is_status != out_item_o.is_status ||
              want.path_error != out_item_o.path_error) begin
            report("field differs,", want, out_item_o);
          end else if (!want.is_status) begin
            n_bytes++;
          end
        end
      end
      if (in_took) begin
        n_chars++;
        decode_beat(in_item_i);
      end
      // only count dead cycles while something is still owed
      if ((enc_chars.size() != 0 || push || decoded_out.size() != 0) &&
          !in_took && !(pop && !empty)) begin
        idle_run++;
      end else begin
        idle_run = 0;
      end
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d beats outstanding",
               idle_run, decoded_out.size());
      $display("[url_path_percent_decoder] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: offers the oldest queued character, idles at random
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (push && in_took) void'(enc_chars.pop_front());
    if (!push || in_took) begin
      if (rst_ni && enc_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push      <= 1'b1;
        in_item_i <= enc_chars[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random pops, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_char(logic [7:0] c);
    in_item_t it;
    it.in_char       = c;
    it.end_of_string = 1'b0;
    enc_chars.push_back(it);
    queued_total++;
  endtask

  // the character field is don't-care on an end beat, so fill it with noise
  task automatic queue_end();
    in_item_t it;
    it.in_char       = 8'($urandom);
    it.end_of_string = 1'b1;
    enc_chars.push_back(it);
    queued_total++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  function automatic logic [7:0] hex_of(logic [3:0] n);
    if (n < 10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  // one path: mostly well-formed tokens, some raw noise and broken escapes
  task automatic add_path();
    int         r;
    logic [7:0] e;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(0, 255)));
      queue_end();
      return;
    end
    repeat ($urandom_range(0, 7)) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_char(r[0] ? 8'("/") : 8'($urandom_range(8'h61, 8'h7a)));
      end else if (r < 47) begin
        queue_char(CH_DOT);
      end else if (r < 75) begin
        // valid escape, now and then of a byte the decoder treats specially
        case ($urandom_range(0, 7))
          0:       e = CH_NUL;
          1:       e = CH_BACKSLASH;
          2:       e = CH_DOT;
          default: e = 8'($urandom);
        endcase
        queue_char(CH_PERCENT);
        queue_char(hex_of(e[7:4]));
        queue_char(hex_of(e[3:0]));
      end else if (r < 85) begin
        queue_char(8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        queue_char(CH_PERCENT);
        queue_char(8'($urandom));
        queue_char(8'($urandom));
      end else begin
        queue_char($urandom_range(0, 1) ? CH_QUERY : CH_HASH);
      end
    end
    // sometimes leave an escape hanging at the end
    case ($urandom_range(0, 9))
      0: queue_char(CH_PERCENT);
      1: begin
        queue_char(CH_PERCENT);
        case ($urandom_range(0, 3))
          0:       queue_char(hex_of(4'($urandom)));
          1:       queue_char($urandom_range(0, 1) ? CH_QUERY : CH_HASH);
          2:       queue_char(CH_DOT);
          default: queue_char(8'($urandom));
        endcase
      end
      default: ;
    endcase
    queue_end();
  endtask

  // block idle: nothing queued, nothing offered, nothing owed, then settle
  task automatic wait_idle();
    while (enc_chars.size() != 0 || push || decoded_out.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_cap(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    capacity = v;
    n_caps++;
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int send_pct, int recv_pct, logic [CFG_W-1:0] cap, int n);
    int start;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_cap(cap);
    start = queued_total;
    while (queued_total - start < n) add_path();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 68;
    write_cap(CAP_RESET);

    // escapes in both cases, raw top byte, and a dot pair that rejects
    queue_text("%41%fF");
    queue_char(8'hff);
    queue_text("..");
    queue_end();
    // query mark in a hex digit place fails the path, later characters ignored
    queue_text("%?1x");
    queue_end();
    // raw NUL character
    queue_char(CH_NUL);
    queue_end();
    // end with one held character that stops the path
    queue_text("%#");
    queue_end();
    // query ends the path, broken escape after it does not matter
    queue_text("a?%Z");
    queue_end();

    // capacity lowered mid-path: count is already two, so the next byte fails
    wait_idle();
    queue_text("bc");
    wait_idle();
    write_cap(13'd3);
    queue_text("de");
    queue_end();

    // sender idles lightly, receiver heavily
    run_random(30, 68, 13'd1, 20);   // capacity below two, every byte fails
    run_random(30, 68, 13'd0, 10);
    run_random(30, 68, 13'd5, 70);

    // the other way round
    run_random(68, 30, 13'd2, 30);
    run_random(68, 30, 13'd12, 70);

    // no idling; receiver holds off so the job queue fills and input stalls
    run_random(0, 0, CAP_RESET, 60);
    hold_req = 1'b1;

    // largest register value acts as the build maximum
    run_random(0, 0, 13'h1fff, 30);

    wait_idle();
    $display("covered %0d input beats over %0d paths (%0d rejected), %0d bytes checked",
             n_chars, n_paths, n_rejected, n_bytes);
    $display("%0d capacity writes, %0d cycles with input held off, %0d mismatches",
             n_caps, stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("[url_path_percent_decoder] OK");
    end else begin
      $display("[url_path_percent_decoder] ERROR");
    end
    $finish;
  end

endmodule
